// ----- rtl/core/tprs_pkg.sv -----
// ----------------------------------------------------------------------------
// tprs_pkg: shared types and constants for the two-path route selector
// Fixed-point constants, register indexes, payload structs, ctrl/dp structs.
// ----------------------------------------------------------------------------
package tprs_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  function automatic int kq(input int hundredths);
    kq = ((hundredths << FRAC_BITS) + 50) / 100;
  endfunction

  localparam int BASE_B = kq(5);
  localparam int K035   = kq(35);
  localparam int K045   = kq(45);
  localparam int K090   = kq(90);
  localparam int K025   = kq(25);
  localparam int K012   = kq(12);
  localparam int K060   = kq(60);
  localparam int K088   = ONE_Q - K012;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_CAPACITY  = 3'd1;
  localparam logic [2:0] REG_PERIOD    = 3'd2;
  localparam logic [2:0] REG_HOLD_OFF  = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_GUARD     = 3'd5;
  localparam logic [2:0] REG_BURST_MRG = 3'd6;
  localparam logic [2:0] REG_CALM_MRG  = 3'd7;

  localparam logic [1:0] MODE_ACCUM    = 2'd0;
  localparam logic [1:0] MODE_TRIGGER  = 2'd1;
  localparam logic [1:0] MODE_PERIODIC = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;  // unused, acts as periodic

  typedef struct packed {
    logic [9:0]  queue_a_count;
    logic [9:0]  queue_b_count;
    logic [31:0] time_ms;
    logic        burst_flag;
  } sample_t;

  typedef struct packed {
    logic        path_selected;
    logic        switched;
    logic [15:0] change_count;
    logic [15:0] tail_count;
    logic [19:0] accum_level;
    logic [15:0] memory_a_level;
    logic [15:0] memory_b_level;
    logic [12:0] norm_a;
    logic [12:0] norm_b;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  queue_capacity;
    logic [15:0] recompute_period;
    logic [15:0] hold_off_time;
    logic [15:0] accum_threshold;
    logic [15:0] switch_guard;
    logic [15:0] burst_margin;
    logic [15:0] calm_margin;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture sample, start divider on A
    logic div_b;     // restart divider on B
    logic div_step;  // one restoring-division step
    logic div_done_a;// store quotient A
    logic div_done_b;// store quotient B
    logic leak;      // update leaky memories
    logic terms;     // memory terms / accumulator products
    logic decide;    // final decision and state commit
  } dp_cmd_t;

endpackage

// ----- rtl/core/tprs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tprs_ctrl: sequencer for the route selector
// Walks one sample through divide, leak, term and decide steps.
// ----------------------------------------------------------------------------
module tprs_ctrl
  import tprs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic    out_free,
  output logic    in_rdy,
  output logic    res_load,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVA  = 3'd1;
  localparam logic [2:0] S_DIVB  = 3'd2;
  localparam logic [2:0] S_LEAK  = 3'd3;
  localparam logic [2:0] S_TERMS = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_NORM  = 3'd6;  // quotient B lands in its register

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  localparam logic [4:0] DIV_LAST = 5'(FRAC_BITS + 10 - 1);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_rdy     = 1'b0;
    res_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          cmd.div_done_a = 1'b1;
          cnt_next = '0;
          state_next = S_DIVB;
        end
      end
      S_DIVB: begin
        if (cnt == '0) begin
          cmd.div_b = 1'b1;
          cnt_next = 5'd1;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next = cnt + 5'd1;
          if (cnt == DIV_LAST + 5'd1) begin
            cmd.div_done_b = 1'b1;
            state_next = S_NORM;
          end
        end
      end
      S_NORM: begin
        state_next = S_LEAK;
      end
      S_LEAK: begin
        cmd.leak = 1'b1;
        state_next = S_TERMS;
      end
      S_TERMS: begin
        cmd.terms = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (out_free) begin
          cmd.decide = 1'b1;
          res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.leak, cmd.terms, cmd.decide}))
    else $error("overlapping phase commands");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_rdy)
    else $error("accepted a second sample while busy");
  a_dec_after_terms: assert property (@(posedge clk) disable iff (rst)
    cmd.terms |=> state == S_DEC)
    else $error("terms not followed by decide");

endmodule

// ----- rtl/core/tprs_dp.sv -----
// ----------------------------------------------------------------------------
// tprs_dp: datapath of the route selector
// Serial divider for normalising, leaky memories, accumulator and counters.
// ----------------------------------------------------------------------------
module tprs_dp
  import tprs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  input  sample_t sample,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int NW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 10;

  sample_t smp;
  logic [DW-1:0] dividend;
  logic [10:0]   rem;
  logic [DW-1:0] quo;
  logic [NW-1:0] na, nb;

  logic          current_path, ever_switched;
  logic [15:0]   leak_a, leak_b;
  logic [19:0]   accumulator;
  logic [31:0]   last_switch_ms, allowed_after_ms;
  logic [15:0]   changes, tail_changes;

  logic [17:0]   term35_c, term35_o, term45_c, term45_o;
  logic [32:0]   acc_prod;

  // restoring division: count<<F / capacity, one bit per step
  logic [11:0] rem_sh;
  always_comb rem_sh = {rem, dividend[DW-1]};

  function automatic logic [NW-1:0] norm_of(input logic [9:0] c, input logic [DW-1:0] q,
                                            input logic [9:0] cap);
    logic [NW-1:0] r;
    if (cap == '0) r = '0;
    else if (c >= cap) r = NW'(ONE_Q);
    else r = q[NW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp      <= sample;
      dividend <= {sample.queue_a_count, {FRAC_BITS{1'b0}}};
      rem      <= '0;
    end else if (cmd.div_b) begin
      dividend <= {smp.queue_b_count, {FRAC_BITS{1'b0}}};
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[DW-2:0], 1'b0};
      if (rem_sh >= {2'b0, cfg.queue_capacity}) begin
        rem <= 11'(rem_sh - {2'b0, cfg.queue_capacity});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[10:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  // quotient is complete the cycle after the last step
  logic done_a_d, done_b_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      done_a_d <= 1'b0;
      done_b_d <= 1'b0;
    end else begin
      done_a_d <= cmd.div_done_a;
      done_b_d <= cmd.div_done_b;
    end
  end
  always_ff @(posedge clk) begin
    if (done_a_d) na <= norm_of(smp.queue_a_count, quo, cfg.queue_capacity);
    if (done_b_d) nb <= norm_of(smp.queue_b_count, quo, cfg.queue_capacity);
  end

  // leaky memory update
  function automatic logic [15:0] leak_upd(input logic [15:0] l, input logic [NW-1:0] n);
    logic [31:0] v;
    v = 32'(l) * 32'(K090) + 32'(K025) * 32'(n) + 32'(ONE_Q / 2);
    v = v >> FRAC_BITS;
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [17:0] mterm(input int k, input logic [15:0] l);
    logic [31:0] v;
    v = (32'(k) * 32'(l) + 32'(ONE_Q / 2)) >> FRAC_BITS;
    return v[17:0];
  endfunction

  logic [15:0] mc, mo;
  always_comb begin
    mc = current_path ? leak_b : leak_a;
    mo = current_path ? leak_a : leak_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leak_a <= '0;
      leak_b <= '0;
    end else if (cmd.leak) begin
      leak_a <= leak_upd(leak_a, na);
      leak_b <= leak_upd(leak_b, nb);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.terms) begin
      term35_c <= mterm(K035, mc);
      term35_o <= mterm(K035, mo);
      term45_c <= mterm(K045, mc);
      term45_o <= mterm(K045, mo);
      acc_prod <= 33'(accumulator) * 33'(K088);
    end
  end

  // decision
  logic [NW-1:0] qc, qo;
  logic [19:0]   bc, bo;
  logic signed [21:0] diff;
  logic signed [40:0] sum;
  logic [40:0]   sum_r;
  logic [19:0]   acc_new, acc_fin;
  logic [19:0]   eff_c, eff_o;
  logic [15:0]   margin;
  logic          due, want, next_path, blocked, sw;
  logic [32:0]   end_ms;

  always_comb begin
    qc = current_path ? nb : na;
    qo = current_path ? na : nb;
    bc = current_path ? 20'(BASE_B) : 20'd0;
    bo = current_path ? 20'd0 : 20'(BASE_B);
    diff = 22'(bc + 20'(qc) + 20'(term35_c)) - 22'(bo + 20'(qo) + 20'(term35_o));
    sum = $signed({8'b0, acc_prod}) + 41'sd0 + 41'(K060) * 41'(diff);
    sum_r = 41'(sum) + 41'(ONE_Q / 2);
    if (sum <= 0) acc_new = '0;
    else if ((sum_r >> FRAC_BITS) > 41'hFFFFF) acc_new = 20'hFFFFF;
    else acc_new = sum_r[FRAC_BITS +: 20];
    eff_c = bc + 20'(qc) + 20'(term45_c);
    eff_o = bo + 20'(qo) + 20'(term45_o);
    margin = smp.burst_flag ? cfg.burst_margin : cfg.calm_margin;
    due = !ever_switched || (smp.time_ms >= last_switch_ms &&
          (smp.time_ms - last_switch_ms) >= 32'(cfg.recompute_period));
    acc_fin   = '0;
    want      = 1'b0;
    next_path = ~current_path;
    if (cfg.mode == MODE_ACCUM) begin
      acc_fin = acc_new;
      if (acc_new >= 20'(cfg.accum_threshold) &&
          21'(eff_o) + 21'(cfg.switch_guard) < 21'(eff_c)) begin
        want = 1'b1;
        acc_fin = '0;
      end
    end else if (cfg.mode == MODE_TRIGGER) begin
      want = 21'(bo) + 21'(qo) + 21'(margin) < 21'(bc) + 21'(qc);
    end else begin
      want = due;
      next_path = (20'(na) <= 20'(BASE_B) + 20'(nb)) ? 1'b0 : 1'b1;
    end
    blocked = ever_switched && smp.time_ms < allowed_after_ms;
    sw = want && next_path != current_path && !blocked;
    end_ms = 33'(smp.time_ms) + 33'(cfg.hold_off_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_path     <= 1'b0;
      ever_switched    <= 1'b0;
      accumulator      <= '0;
      last_switch_ms   <= '0;
      allowed_after_ms <= '0;
      changes          <= '0;
      tail_changes     <= '0;
    end else if (cmd.decide) begin
      accumulator <= acc_fin;
      if (sw) begin
        current_path     <= next_path;
        ever_switched    <= 1'b1;
        last_switch_ms   <= smp.time_ms;
        allowed_after_ms <= end_ms[32] ? 32'hFFFFFFFF : end_ms[31:0];
        if (changes != 16'hFFFF) changes <= changes + 16'd1;
        if (!smp.burst_flag && tail_changes != 16'hFFFF)
          tail_changes <= tail_changes + 16'd1;
      end
    end
  end

  always_comb begin
    result.path_selected  = sw ? next_path : current_path;
    result.switched       = sw;
    result.change_count   = (sw && changes != 16'hFFFF) ? changes + 16'd1 : changes;
    result.tail_count     = (sw && !smp.burst_flag && tail_changes != 16'hFFFF)
                            ? tail_changes + 16'd1 : tail_changes;
    result.accum_level    = acc_fin;
    result.memory_a_level = leak_a;
    result.memory_b_level = leak_b;
    result.norm_a         = na;
    result.norm_b         = nb;
  end

  a_tail_le: assert property (@(posedge clk) disable iff (rst)
    tail_changes <= changes) else $error("tail count above change count");
  a_sw_flips: assert property (@(posedge clk) disable iff (rst)
    cmd.decide && sw |=> current_path != $past(current_path))
    else $error("switch did not change path");
  a_norm_max: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> na <= NW'(ONE_Q) && nb <= NW'(ONE_Q))
    else $error("normalised value above one");

endmodule

// ----- rtl/core/two_path_route_selector.sv -----
// ----------------------------------------------------------------------------
// two_path_route_selector: picks path A or B from queue occupancy samples
// Top level: config registers, sequencer, datapath and output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one sample beat (queue counts, time, burst flag).
//   out_valid/out_ready carry one result beat per sample.
//   cfg_valid/cfg_ready write register cfg_index with cfg_data; always ready.
//     Write only while idle. Indexes 0 to 7 each select a register.
// From sample accept to result valid: two 22-step
//   restoring divisions (serial divider, one quotient bit per cycle) for the
//   two normalised occupancies, then settle, leak, term and decide steps.
// A new sample is accepted only after the previous one has finished decide.
// The next sample is taken while a result still waits in the output register.
// Reset (rst, synchronous): registers to defaults, path A, memories and
//   counters cleared, no result pending.
// Receiver stall: the finished sample waits in decide until the output
//   register is free; no beat is dropped.
// ----------------------------------------------------------------------------
module two_path_route_selector
  import tprs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sample_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  result_t result;
  logic    res_load, in_rdy;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = in_rdy;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode             <= 2'd0;
      cfg.queue_capacity   <= 10'd20;
      cfg.recompute_period <= 16'd500;
      cfg.hold_off_time    <= 16'd700;
      cfg.accum_threshold  <= 16'd901;
      cfg.switch_guard     <= 16'd246;
      cfg.burst_margin     <= 16'd737;
      cfg.calm_margin      <= 16'd123;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:      cfg.mode             <= cfg_data[1:0];
        REG_CAPACITY:  cfg.queue_capacity   <= cfg_data[9:0];
        REG_PERIOD:    cfg.recompute_period <= cfg_data;
        REG_HOLD_OFF:  cfg.hold_off_time    <= cfg_data;
        REG_THRESHOLD: cfg.accum_threshold  <= cfg_data;
        REG_GUARD:     cfg.switch_guard     <= cfg_data;
        REG_BURST_MRG: cfg.burst_margin     <= cfg_data;
        REG_CALM_MRG:  cfg.calm_margin      <= cfg_data;
        default: ;
      endcase
    end
  end

  tprs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_valid && in_rdy),
    .out_free (out_free),
    .in_rdy   (in_rdy),
    .res_load (res_load),
    .cmd      (cmd)
  );

  tprs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sample (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) out_data <= result;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !res_load)
    else $error("result overwritten while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_valid) else $error("loaded result not shown");

endmodule
